FILE: rtl/core/hfs_pkg.sv
// hfs_pkg: shared constants, types and the sRGB threshold table
// used by the half-float to sRGB8 pixel converter modules; no dependencies
package hfs_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int LIN_W      = FRAC_BITS + 1;
    localparam int WORD_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int HEAD_W     = 16;
    localparam int CFG_W      = 16;
    localparam int ROM_DEPTH  = 255;
    localparam int BIG_W      = 320;
    localparam int POWER_DEN  = 10761;
    localparam int LINEAR_DEN = 65892;

    localparam logic [4:0]        EXP_MAX   = 5'h1f;
    localparam logic [HEAD_W-1:0] HEAD_ONE  = 16'd256;
    localparam logic [LIN_W-1:0]  LIN_ONE   = LIN_W'(1) << FRAC_BITS;

    // register indexes
    typedef enum logic {
        CFG_HDR_MODE = 1'b0,
        CFG_HEADROOM = 1'b1
    } t_cfg_idx;

    typedef logic [LIN_W-1:0] t_rom [ROM_DEPTH];

    // thresholds: ceil(2^F * inverse_srgb((k-0.5)/255)), exact integer math
    function automatic t_rom build_rom();
        t_rom              rom;
        logic [BIG_W-1:0]  den12;
        logic [BIG_W-1:0]  target;
        logic [BIG_W-1:0]  trial;
        logic [31:0]       lo;
        logic [31:0]       hi;
        logic [31:0]       mid;
        logic [63:0]       num;
        den12 = BIG_W'(1);
        for (int i = 0; i < 12; i++) den12 = den12 * BIG_W'(POWER_DEN);
        for (int k = 1; k <= ROM_DEPTH; k++) begin
            if (k <= 10) begin
                num = 64'(10 * (2 * k - 1)) << FRAC_BITS;
                rom[k-1] = LIN_W'((num + 64'(LINEAR_DEN - 1)) / 64'(LINEAR_DEN));
            end else begin
                target = BIG_W'(1);
                for (int i = 0; i < 12; i++) target = target * BIG_W'(40 * k + 541);
                target = target << (5 * FRAC_BITS);
                lo = 32'd0;
                hi = 32'd1 << FRAC_BITS;
                for (int it = 0; it < LIN_W + 2; it++) begin
                    if (hi - lo > 32'd1) begin
                        mid = lo + (hi - lo) / 32'd2;
                        trial = den12;
                        for (int i = 0; i < 5; i++) trial = trial * BIG_W'(mid);
                        if (trial >= target) hi = mid;
                        else lo = mid;
                    end
                end
                rom[k-1] = LIN_W'(hi);
            end
        end
        return rom;
    endfunction

    localparam t_rom SRGB_ROM = build_rom();

endpackage

FILE: rtl/core/hfs_pix_in_if.sv
// hfs_pix_in_if: input pixel channel, valid/ready with three channel words
// depends on hfs_pkg
interface hfs_pix_in_if import hfs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] red_in;
    logic [WORD_W-1:0] green_in;
    logic [WORD_W-1:0] blue_in;

    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

FILE: rtl/core/hfs_pix_out_if.sv
// hfs_pix_out_if: output pixel channel, valid/ready with three sRGB bytes
// depends on hfs_pkg
interface hfs_pix_out_if import hfs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] red_out;
    logic [BYTE_W-1:0] green_out;
    logic [BYTE_W-1:0] blue_out;

    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

FILE: rtl/core/hfs_linearize.sv
// hfs_linearize: one IEEE half times the 8.8 headroom to saturated linear fixed point
// depends on hfs_pkg
module hfs_linearize import hfs_pkg::*; (
    input  logic [WORD_W-1:0] i_word,
    input  logic [HEAD_W-1:0] i_scale,
    output logic [LIN_W-1:0]  o_lin
);
    localparam int PROD_W = 11 + HEAD_W;
    localparam int WIDE_W = PROD_W + 29;
    localparam int RSH    = 32 - FRAC_BITS;

    logic              sign;
    logic [4:0]        expo;
    logic [9:0]        frac;
    logic [10:0]       mant;
    logic [4:0]        lsh;
    logic [PROD_W-1:0] prod;
    logic [WIDE_W-1:0] wide;
    logic [WIDE_W-1:0] lin_full;

    assign sign = i_word[15];
    assign expo = i_word[14:10];
    assign frac = i_word[9:0];

    // subnormals take exponent one without hidden bit
    assign mant = (expo == 5'd0) ? {1'b0, frac} : {1'b1, frac};
    assign lsh  = (expo == 5'd0) ? 5'd0 : expo - 5'd1;
    assign prod = PROD_W'(mant) * PROD_W'(i_scale);
    assign wide = WIDE_W'(prod) << lsh;
    assign lin_full = wide >> RSH;

    // special cases and saturation
    always_comb begin
        if (sign) begin
            o_lin = '0;
        end else if (expo == EXP_MAX) begin
            o_lin = (frac != 10'd0) ? '0 : LIN_ONE;
        end else if (lin_full > WIDE_W'(LIN_ONE)) begin
            o_lin = LIN_ONE;
        end else begin
            o_lin = lin_full[LIN_W-1:0];
        end
    end
endmodule

FILE: rtl/core/hfs_encode.sv
// hfs_encode: counts thresholds at or below the linear value by binary search
// depends on hfs_pkg (threshold table)
module hfs_encode import hfs_pkg::*; (
    input  logic [LIN_W-1:0]  i_lin,
    output logic [BYTE_W-1:0] o_byte
);
    logic [BYTE_W-1:0] idx;
    logic [BYTE_W-1:0] cand;

    // thresholds rise with k, so one bit per step settles the count
    always_comb begin
        idx  = '0;
        cand = '0;
        for (int b = BYTE_W - 1; b >= 0; b--) begin
            cand = idx | (BYTE_W'(1) << b);
            if (SRGB_ROM[cand - BYTE_W'(1)] <= i_lin) idx = cand;
        end
        o_byte = idx;
    end
endmodule

FILE: rtl/core/half_float_to_srgb8_pixel_top.sv
// half_float_to_srgb8_pixel_top: pixel converter, half floats or bytes to sRGB bytes
// two register stages, linearize then table search
// throughput: one request per cycle while the output side is not stalled
// reset clears pipeline valid bits, hdr_mode to 0 and headroom to 1.0 (256)
// depends on hfs_pkg, hfs_pix_in_if, hfs_pix_out_if, hfs_linearize, hfs_encode
module half_float_to_srgb8_pixel_top import hfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    hfs_pix_in_if.sink        i_pix,
    hfs_pix_out_if.source     o_pix
);
    logic               r_hdr_mode;
    logic [HEAD_W-1:0]  r_headroom;
    logic [HEAD_W-1:0]  scale;

    logic               r_v1;
    logic               r_hdr1;
    logic [LIN_W-1:0]   r_lin  [3];
    logic [BYTE_W-1:0]  r_raw  [3];
    logic [LIN_W-1:0]   n_lin  [3];
    logic [BYTE_W-1:0]  enc    [3];
    logic [WORD_W-1:0]  word   [3];

    logic               r_v2;
    logic [BYTE_W-1:0]  r_out  [3];

    logic               en1;
    logic               en2;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_mode <= 1'b0;
            r_headroom <= HEAD_ONE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HDR_MODE: r_hdr_mode <= i_cfg_data[0];
                CFG_HEADROOM: r_headroom <= i_cfg_data[HEAD_W-1:0];
                default: ;
            endcase
        end
    end

    assign scale = (r_headroom < HEAD_ONE) ? HEAD_ONE : r_headroom;

    // stall control, a stage advances when it is empty or the next one advances
    assign en2         = !r_v2 || o_pix.ready;
    assign en1         = !r_v1 || en2;
    assign i_pix.ready = en1;

    assign word[0] = i_pix.red_in;
    assign word[1] = i_pix.green_in;
    assign word[2] = i_pix.blue_in;

    // per channel datapath
    for (genvar c = 0; c < 3; c++) begin : g_ch
        hfs_linearize u_lin (
            .i_word  (word[c]),
            .i_scale (scale),
            .o_lin   (n_lin[c])
        );
        hfs_encode u_enc (
            .i_lin  (r_lin[c]),
            .o_byte (enc[c])
        );
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_pix.valid;
            if (en2) r_v2 <= r_v1;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_hdr1 <= r_hdr_mode;
            for (int c = 0; c < 3; c++) begin
                r_lin[c] <= n_lin[c];
                r_raw[c] <= word[c][BYTE_W-1:0];
            end
        end
        if (en2) begin
            for (int c = 0; c < 3; c++) begin
                r_out[c] <= r_hdr1 ? enc[c] : r_raw[c];
            end
        end
    end

    assign o_pix.valid     = r_v2;
    assign o_pix.red_out   = r_out[0];
    assign o_pix.green_out = r_out[1];
    assign o_pix.blue_out  = r_out[2];
endmodule

FILE: rtl/core/hfs_checker.sv
// hfs_checker: port-level assertions for the pixel converter, bound to the top
// depends on hfs_pkg, half_float_to_srgb8_pixel_top
module hfs_checker import hfs_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [BYTE_W-1:0] i_red,
    input logic [BYTE_W-1:0] i_green,
    input logic [BYTE_W-1:0] i_blue
);
    // a stalled result holds its bytes
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_red)
            && $stable(i_green) && $stable(i_blue))
        else $error("stalled result changed");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // an empty output side never blocks requests
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request blocked with empty output");

    // output ready always gives input ready in the same cycle
    a_ready_when_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("request blocked while result taken");
endmodule

bind half_float_to_srgb8_pixel_top hfs_checker u_hfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_red       (o_pix.red_out),
    .i_green     (o_pix.green_out),
    .i_blue      (o_pix.blue_out)
);
